// ----- src/julian_day_to_calendar_date_defines.svh -----
// Assertion macros shared by the date converter RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef JULIAN_DAY_TO_CALENDAR_DATE_DEFINES_SVH
`define JULIAN_DAY_TO_CALENDAR_DATE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JDTCD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jdtcd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define JDTCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jdtcd assertion failed");

`endif

// ----- src/jdtcd_pkg.sv -----
// Types and constants for the modified Julian date to calendar converter.
// No dependencies; imported by jdtcd_date, jdtcd_time, the top module and the testbench.
package jdtcd_pkg;

    typedef struct packed {
        logic signed [20:0] mjd_day;
        logic [31:0]        day_fraction;
    } jdtcd_in_t;

    typedef struct packed {
        logic signed [13:0] year;
        logic [3:0]         month;
        logic [4:0]         day_of_month;
        logic [4:0]         hour;
        logic [5:0]         minute;
        logic [5:0]         second_whole;
        logic [15:0]        second_fraction;
    } jdtcd_out_t;

    typedef struct packed {
        logic signed [13:0] year;
        logic [3:0]         month;
        logic [4:0]         day_of_month;
    } jdtcd_date_t;

    typedef struct packed {
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second_whole;
        logic [15:0] second_fraction;
    } jdtcd_time_t;

    localparam logic signed [22:0] MJD_TO_JDN      = 23'sd2400001;
    localparam logic [21:0]        GREGORIAN_START = 22'd2299161;
    localparam logic [16:0]        SECONDS_PER_DAY = 17'd86400;

    // Cycles from accepted transfer to registered result of each path.
    localparam int DATE_LATENCY = 12;
    localparam int TIME_LATENCY = 8;

    // floor(30.6001 * e) for the month index e of the Meeus method.
    function automatic logic [8:0] month_start(input logic [3:0] e);
        logic [8:0] offset;
        case (e)
            4'd0:    offset = 9'd0;
            4'd1:    offset = 9'd30;
            4'd2:    offset = 9'd61;
            4'd3:    offset = 9'd91;
            4'd4:    offset = 9'd122;
            4'd5:    offset = 9'd153;
            4'd6:    offset = 9'd183;
            4'd7:    offset = 9'd214;
            4'd8:    offset = 9'd244;
            4'd9:    offset = 9'd275;
            4'd10:   offset = 9'd306;
            4'd11:   offset = 9'd336;
            4'd12:   offset = 9'd367;
            4'd13:   offset = 9'd397;
            4'd14:   offset = 9'd428;
            4'd15:   offset = 9'd459;
            default: offset = 9'd0;
        endcase
        return offset;
    endfunction

endpackage

// ----- src/jdtcd_const_div.sv -----
// Two-stage unsigned divider by a constant: reciprocal estimate, then one correction.
// Standalone; used by the date and time-of-day paths.
module jdtcd_const_div #(
    parameter int WIDTH          = 24,
    parameter int DIVISOR        = 3,
    parameter int QUOTIENT_WIDTH = 8
) (
    input  logic                      clk,
    input  logic [WIDTH-1:0]          dividend,
    output logic [QUOTIENT_WIDTH-1:0] quotient
);

    // floor(2^WIDTH / DIVISOR): the estimate is low by at most one
    localparam logic [WIDTH-1:0] RECIP = WIDTH'((64'd1 << WIDTH) / DIVISOR);
    localparam logic [WIDTH-1:0] DIV_W = WIDTH'(DIVISOR);

    logic [2*WIDTH-1:0]        product;
    logic [WIDTH-1:0]          dividend_reg;
    logic [QUOTIENT_WIDTH-1:0] estimate_reg;
    logic [QUOTIENT_WIDTH-1:0] estimate_next;
    logic [WIDTH-1:0]          remainder;
    logic [QUOTIENT_WIDTH-1:0] quotient_reg;
    logic [QUOTIENT_WIDTH-1:0] quotient_next;

    assign product       = (2*WIDTH)'(dividend) * (2*WIDTH)'(RECIP);
    assign estimate_next = product[WIDTH +: QUOTIENT_WIDTH];

    always_ff @(posedge clk)
    begin
        dividend_reg <= dividend;
        estimate_reg <= estimate_next;
    end

    assign remainder     = dividend_reg - (WIDTH'(estimate_reg) * DIV_W);
    assign quotient_next = estimate_reg + QUOTIENT_WIDTH'(remainder >= DIV_W);

    always_ff @(posedge clk)
    begin
        quotient_reg <= quotient_next;
    end

    assign quotient = quotient_reg;

endmodule

// ----- src/jdtcd_date.sv -----
// Calendar date path: MJD day count to year, month and day by the Meeus method.
// Depends on jdtcd_pkg and three jdtcd_const_div units.
module jdtcd_date (
    input  logic                  clk,
    input  logic signed [20:0]    mjd_day,
    output jdtcd_pkg::jdtcd_date_t date
);
    import jdtcd_pkg::*;

    // stage 1: Julian day number and calendar select
    logic signed [22:0] jdn_sum;
    logic [21:0]        jdn1_reg;
    logic               greg1_reg;
    logic [23:0]        x1_next;

    assign jdn_sum = $signed({{2{mjd_day[20]}}, mjd_day}) + MJD_TO_JDN;

    always_ff @(posedge clk)
    begin
        jdn1_reg  <= jdn_sum[21:0];
        greg1_reg <= (jdn_sum[21:0] >= GREGORIAN_START);
    end

    // 4*jdn - 7468865 over 146097 gives the century correction alpha
    assign x1_next = greg1_reg ? ({jdn1_reg, 2'b00} - 24'd7468865) : 24'd0;

    logic [5:0] alpha;

    jdtcd_const_div #(.WIDTH(24), .DIVISOR(146097), .QUOTIENT_WIDTH(6)) u_div_alpha (
        .clk      (clk),
        .dividend (x1_next),
        .quotient (alpha)
    );

    logic [21:0] jdn2_reg, jdn3_reg;
    logic        greg2_reg, greg3_reg;

    always_ff @(posedge clk)
    begin
        jdn2_reg  <= jdn1_reg;
        jdn3_reg  <= jdn2_reg;
        greg2_reg <= greg1_reg;
        greg3_reg <= greg2_reg;
    end

    // stage 4: b = a + 1524
    logic [21:0] a_next;
    logic [21:0] b4_reg;

    assign a_next = greg3_reg
                  ? (jdn3_reg + 22'd1 + 22'(alpha) - 22'(alpha[5:2]))
                  : jdn3_reg;

    always_ff @(posedge clk)
    begin
        b4_reg <= a_next + 22'd1524;
    end

    // stage 5: 100*b - 12210 for the year count
    logic [28:0] x2_5_reg;
    logic [21:0] b5_reg;

    always_ff @(posedge clk)
    begin
        x2_5_reg <= (29'(b4_reg) * 29'd100) - 29'd12210;
        b5_reg   <= b4_reg;
    end

    logic [13:0] c_q;

    jdtcd_const_div #(.WIDTH(29), .DIVISOR(36525), .QUOTIENT_WIDTH(14)) u_div_year (
        .clk      (clk),
        .dividend (x2_5_reg),
        .quotient (c_q)
    );

    logic [21:0] b6_reg, b7_reg;

    always_ff @(posedge clk)
    begin
        b6_reg <= b5_reg;
        b7_reg <= b6_reg;
    end

    // stage 8: days left after whole years, t = b - floor(365.25*c)
    logic [24:0] d_prod;
    logic [9:0]  t_next;
    logic [9:0]  t8_reg;
    logic [13:0] c8_reg;

    assign d_prod = 25'(c_q) * 25'd1461;
    assign t_next = 10'(b7_reg - 22'(d_prod[24:2]));

    always_ff @(posedge clk)
    begin
        t8_reg <= t_next;
        c8_reg <= c_q;
    end

    // stage 9: scale for the month count
    logic [22:0] x3_9_reg;
    logic [9:0]  t9_reg;
    logic [13:0] c9_reg;

    always_ff @(posedge clk)
    begin
        x3_9_reg <= 23'(t8_reg) * 23'd10000;
        t9_reg   <= t8_reg;
        c9_reg   <= c8_reg;
    end

    logic [3:0] e_q;

    jdtcd_const_div #(.WIDTH(23), .DIVISOR(306001), .QUOTIENT_WIDTH(4)) u_div_month (
        .clk      (clk),
        .dividend (x3_9_reg),
        .quotient (e_q)
    );

    logic [9:0]  t10_reg, t11_reg;
    logic [13:0] c10_reg, c11_reg;

    always_ff @(posedge clk)
    begin
        t10_reg <= t9_reg;
        t11_reg <= t10_reg;
        c10_reg <= c9_reg;
        c11_reg <= c10_reg;
    end

    // stage 12: day, month and year
    logic [3:0]  month_next;
    logic [4:0]  day_next;
    logic [13:0] year_next;
    jdtcd_date_t date_reg;

    assign month_next = (e_q < 4'd14) ? (e_q - 4'd1) : (e_q - 4'd13);
    assign day_next   = 5'(t11_reg - 10'(month_start(e_q)));
    assign year_next  = 14'(c11_reg) - ((month_next > 4'd2) ? 14'd4716 : 14'd4715);

    always_ff @(posedge clk)
    begin
        date_reg.year         <= $signed(year_next);
        date_reg.month        <= month_next;
        date_reg.day_of_month <= day_next;
    end

    assign date = date_reg;

endmodule

// ----- src/jdtcd_time.sv -----
// Time-of-day path: Q0.FRACTION_BITS day fraction to hour, minute, second, sub-second.
// Depends on jdtcd_pkg and two jdtcd_const_div units.
module jdtcd_time #(
    parameter int FRACTION_BITS = 32
) (
    input  logic                   clk,
    input  logic [31:0]            day_fraction,
    output jdtcd_pkg::jdtcd_time_t tod
);
    import jdtcd_pkg::*;

    localparam int FRAC_W   = (FRACTION_BITS < 32) ? FRACTION_BITS : 32;
    localparam int SCALED_W = FRACTION_BITS + 17;

    // stage 1: drop bits above the binary point
    logic [FRAC_W-1:0] frac_reg;

    always_ff @(posedge clk)
    begin
        frac_reg <= day_fraction[FRAC_W-1:0];
    end

    // stage 2: seconds of the day in fixed point
    logic [SCALED_W-1:0] scaled_reg;

    always_ff @(posedge clk)
    begin
        scaled_reg <= SCALED_W'(frac_reg) * SCALED_W'(SECONDS_PER_DAY);
    end

    logic [16:0] secs;
    logic [15:0] sub;

    assign secs = scaled_reg[FRACTION_BITS +: 17];
    assign sub  = scaled_reg[FRACTION_BITS-16 +: 16];

    logic [4:0] hour_q;

    jdtcd_const_div #(.WIDTH(17), .DIVISOR(3600), .QUOTIENT_WIDTH(5)) u_div_hour (
        .clk      (clk),
        .dividend (secs),
        .quotient (hour_q)
    );

    logic [16:0] secs3_reg, secs4_reg;
    logic [15:0] sub3_reg, sub4_reg;

    always_ff @(posedge clk)
    begin
        secs3_reg <= secs;
        secs4_reg <= secs3_reg;
        sub3_reg  <= sub;
        sub4_reg  <= sub3_reg;
    end

    // stage 5: seconds within the hour
    logic [11:0] rem5_reg;
    logic [4:0]  hour5_reg;
    logic [15:0] sub5_reg;

    always_ff @(posedge clk)
    begin
        rem5_reg  <= 12'(secs4_reg - (17'(hour_q) * 17'd3600));
        hour5_reg <= hour_q;
        sub5_reg  <= sub4_reg;
    end

    logic [5:0] minute_q;

    jdtcd_const_div #(.WIDTH(12), .DIVISOR(60), .QUOTIENT_WIDTH(6)) u_div_minute (
        .clk      (clk),
        .dividend (rem5_reg),
        .quotient (minute_q)
    );

    logic [11:0] rem6_reg, rem7_reg;
    logic [4:0]  hour6_reg, hour7_reg;
    logic [15:0] sub6_reg, sub7_reg;

    always_ff @(posedge clk)
    begin
        rem6_reg  <= rem5_reg;
        rem7_reg  <= rem6_reg;
        hour6_reg <= hour5_reg;
        hour7_reg <= hour6_reg;
        sub6_reg  <= sub5_reg;
        sub7_reg  <= sub6_reg;
    end

    // stage 8: whole seconds
    jdtcd_time_t tod_reg;

    always_ff @(posedge clk)
    begin
        tod_reg.hour            <= hour7_reg;
        tod_reg.minute          <= minute_q;
        tod_reg.second_whole    <= 6'(rem7_reg - (12'(minute_q) * 12'd60));
        tod_reg.second_fraction <= sub7_reg;
    end

    assign tod = tod_reg;

endmodule

// ----- src/julian_day_to_calendar_date.sv -----
// Converts a modified Julian date (whole days plus Q0.FRACTION_BITS fraction) into
// calendar date and time of day. Each start transfer gives one result, marked by done
// for exactly one cycle; a new transfer can be started every cycle and busy is never
// raised. The date path, which runs three two-stage constant dividers in series
// (century, year, month), is the longer of the two paths. The receiver cannot stall:
// done must be taken in the cycle it appears. Days from Julian day 2299161 on use the
// Gregorian calendar, earlier days the Julian calendar.
// Depends on jdtcd_pkg, jdtcd_date, jdtcd_time and the assertion macros header.
`include "julian_day_to_calendar_date_defines.svh"

module julian_day_to_calendar_date #(
    parameter int FRACTION_BITS = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  jdtcd_pkg::jdtcd_in_t   request,
    output logic                   done,
    output jdtcd_pkg::jdtcd_out_t  result
);
    import jdtcd_pkg::*;

    localparam int PAD_DEPTH = DATE_LATENCY - TIME_LATENCY;

    logic accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // valid bits travel alongside both paths
    logic [DATE_LATENCY-1:0] valid_reg;
    logic [DATE_LATENCY-1:0] valid_next;

    assign valid_next = {valid_reg[DATE_LATENCY-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    jdtcd_date_t date;
    jdtcd_time_t tod;

    jdtcd_date u_date (
        .clk     (clk),
        .mjd_day (request.mjd_day),
        .date    (date)
    );

    jdtcd_time #(.FRACTION_BITS(FRACTION_BITS)) u_time (
        .clk          (clk),
        .day_fraction (request.day_fraction),
        .tod          (tod)
    );

    // hold time-of-day results until the date path catches up
    jdtcd_time_t pad_reg [PAD_DEPTH];

    always_ff @(posedge clk)
    begin
        pad_reg[0] <= tod;
        for (int i = 1; i < PAD_DEPTH; i++)
        begin
            pad_reg[i] <= pad_reg[i-1];
        end
    end

    assign done                   = valid_reg[DATE_LATENCY-1];
    assign result.year            = date.year;
    assign result.month           = date.month;
    assign result.day_of_month    = date.day_of_month;
    assign result.hour            = pad_reg[PAD_DEPTH-1].hour;
    assign result.minute          = pad_reg[PAD_DEPTH-1].minute;
    assign result.second_whole    = pad_reg[PAD_DEPTH-1].second_whole;
    assign result.second_fraction = pad_reg[PAD_DEPTH-1].second_fraction;

    `JDTCD_ASSERT_NEXT(a_transfer_enters, clk, rst_n, accept, valid_reg[0])
    `JDTCD_ASSERT_IMPL(a_month_range, clk, rst_n, done, result.month >= 4'd1 && result.month <= 4'd12)
    `JDTCD_ASSERT_IMPL(a_day_nonzero, clk, rst_n, done, result.day_of_month != 5'd0)
    `JDTCD_ASSERT_IMPL(a_time_range, clk, rst_n, done, result.hour <= 5'd23 && result.minute <= 6'd59 && result.second_whole <= 6'd59)

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// Testbench for julian_day_to_calendar_date: directed and random MJD timestamps.
// A scoreboard predicts every date and time of day and checks it field by field.
// Depends on jdtcd_pkg and the julian_day_to_calendar_date RTL.
module testbench;
    import jdtcd_pkg::*;

    localparam longint JDN_OF_MJD_ZERO     = 2400001;
    localparam longint FIRST_GREGORIAN_JDN = 2299161;
    localparam int     RANDOM_ITEMS        = 1030;
    localparam int     CALM_ITEMS          = 200;
    localparam int     CYCLE_LIMIT         = 200000;
    localparam int     N_DIRECTED          = 20;

    class calendar_scoreboard;
        jdtcd_out_t pending[$];
        int         errors;
        int         transfers;
        int         results;
        int         julian_days;

        function jdtcd_out_t calendar_of(jdtcd_in_t req);
            longint             jdn, a, b, c, d, e, m, alpha, dom, yr;
            longint unsigned    scaled, secs;
            jdtcd_out_t         r;
            jdn = longint'($signed(req.mjd_day)) + JDN_OF_MJD_ZERO;
            a = jdn;
            if (jdn >= FIRST_GREGORIAN_JDN)
            begin
                alpha = (4 * jdn - 7468865) / 146097;
                a = jdn + 1 + alpha - alpha / 4;
            end
            else
            begin
                julian_days++;
            end
            b = a + 1524;
            c = (100 * b - 12210) / 36525;
            d = (1461 * c) / 4;
            e = (10000 * (b - d)) / 306001;
            dom = b - d - (306001 * e) / 10000;
            m = (e < 14) ? e - 1 : e - 13;
            yr = (m > 2) ? c - 4716 : c - 4715;
            r.year = yr[13:0];
            r.month = m[3:0];
            r.day_of_month = dom[4:0];
            // time of day is the fraction times 86400 s, truncated to 1/65536 s
            scaled = {32'd0, req.day_fraction} * 64'd86400;
            secs = scaled >> 32;
            r.hour = 5'(secs / 3600);
            r.minute = 6'((secs % 3600) / 60);
            r.second_whole = 6'(secs % 60);
            r.second_fraction = scaled[31:16];
            return r;
        endfunction

        function void note_request(jdtcd_in_t req);
            transfers++;
            pending.push_back(calendar_of(req));
        endfunction

        function void check_result(jdtcd_out_t got);
            jdtcd_out_t want;
            results++;
            if (pending.size() == 0)
            begin
                $error("result with no transfer pending: %p", got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.year !== want.year)
            begin
                $error("year: expected %0d, got %0d", $signed(want.year), $signed(got.year));
                errors++;
            end
            if (got.month !== want.month)
            begin
                $error("month: expected %0d, got %0d", want.month, got.month);
                errors++;
            end
            if (got.day_of_month !== want.day_of_month)
            begin
                $error("day_of_month: expected %0d, got %0d", want.day_of_month,
                       got.day_of_month);
                errors++;
            end
            if (got.hour !== want.hour)
            begin
                $error("hour: expected %0d, got %0d", want.hour, got.hour);
                errors++;
            end
            if (got.minute !== want.minute)
            begin
                $error("minute: expected %0d, got %0d", want.minute, got.minute);
                errors++;
            end
            if (got.second_whole !== want.second_whole)
            begin
                $error("second_whole: expected %0d, got %0d", want.second_whole,
                       got.second_whole);
                errors++;
            end
            if (got.second_fraction !== want.second_fraction)
            begin
                $error("second_fraction: expected %0d, got %0d", want.second_fraction,
                       got.second_fraction);
                errors++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    jdtcd_in_t  request;
    logic       done;
    jdtcd_out_t result;
    int         cycle_count;

    calendar_scoreboard sb = new();

    // extremes, the calendar switch, leap days and second boundaries
    int directed_day [N_DIRECTED] = '{
        -1048576, 1048575, -1000000, 1000000, 0, -1, -100840, -100841,
        51603, 51604, 15078, 15079, 51544, 60000, 60000, -400000,
        400000, -700000, 1048575, -1048576
    };
    logic [31:0] directed_frac [N_DIRECTED] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001,
        32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
        32'h4000_0000, 32'hC000_0000, 32'h0000_0000, 32'h0000_0000,
        32'h0000_0000, 32'h0000_C22E, 32'h0000_C22F, 32'h7FFF_FFFF,
        32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0000, 32'hFFFF_FFFF
    };

    julian_day_to_calendar_date u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                sb.note_request(request);
            if (done)
                sb.check_result(result);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles", cycle_count);
        $display("Mismatches found");
        $finish;
    end

    // Hold start high until the transfer is taken; returns on the next falling edge.
    task automatic send_transfer(input jdtcd_in_t item);
        request <= item;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    task automatic hold_idle(input int cycles);
        start <= 1'b0;
        repeat (cycles)
        begin
            request <= {21'($urandom()), $urandom()};
            @(negedge clk);
        end
    endtask

    initial
    begin
        jdtcd_in_t item;
        longint    k;
        bit        gaps_on;
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            item.mjd_day = directed_day[i][20:0];
            item.day_fraction = directed_frac[i];
            send_transfer(item);
            if (i % 5 == 4)
                hold_idle($urandom_range(1, 12));
        end

        gaps_on = 1'b1;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            // choose anew between gappy and gap-free stretches every 50 items
            if (i % 50 == 0)
                gaps_on = ($urandom_range(0, 2) != 0);
            case ($urandom_range(0, 4))
                0: item.mjd_day = 21'($urandom());
                1: item.mjd_day = 21'($urandom_range(0, 2000000) - 1000000);
                2: item.mjd_day = 21'(-100840 + $urandom_range(0, 800) - 400);
                3: item.mjd_day = 21'($urandom_range(0, 100000) - 20000);
                default: item.mjd_day = $urandom_range(0, 1)
                                      ? 21'h100000 + 21'($urandom_range(0, 15))
                                      : 21'h0FFFFF - 21'($urandom_range(0, 15));
            endcase
            case ($urandom_range(0, 3))
                0: item.day_fraction = $urandom();
                1: item.day_fraction = $urandom_range(0, 65535);
                2: item.day_fraction = 32'hFFFF_FFFF - $urandom_range(0, 65535);
                default:
                begin
                    // land on or next to a whole second
                    k = longint'($urandom_range(0, 86399));
                    k = ((k << 32) + 86399) / 86400 + longint'($urandom_range(0, 4)) - 2;
                    item.day_fraction = k[31:0];
                end
            endcase
            send_transfer(item);
            if (gaps_on && i < RANDOM_ITEMS - CALM_ITEMS && $urandom_range(0, 3) == 0)
                hold_idle($urandom_range(1, 12));
        end
        start <= 1'b0;

        while (sb.pending.size() > 0)
            @(posedge clk);
        repeat (DATE_LATENCY + 4) @(posedge clk);
        if (sb.pending.size() != 0)
        begin
            $error("%0d expected results never arrived", sb.pending.size());
            sb.errors++;
        end

        $display("Converted %0d timestamps, %0d of them before the Gregorian switch;",
                 sb.transfers, sb.julian_days);
        $display("checked %0d results across the full 21-bit day and 32-bit fraction span",
                 sb.results);
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
